// File: rtl/lirt_pkg.sv
package lirt_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int CMD_W  = 2;
  localparam int SEL_W  = 4;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // register word indexes (byte offset / 16)
  localparam logic [IDX_W-1:0] IDX_TPR        = 6'd8;
  localparam logic [IDX_W-1:0] IDX_EOI        = 6'd11;
  localparam logic [IDX_W-1:0] IDX_SVR        = 6'd15;
  localparam logic [IDX_W-1:0] IDX_ICR_LO     = 6'd48;
  localparam logic [IDX_W-1:0] IDX_ICR_HI     = 6'd49;
  localparam logic [IDX_W-1:0] IDX_LVT_TIMER  = 6'd50;
  localparam logic [IDX_W-1:0] IDX_INIT_COUNT = 6'd56;
  localparam logic [IDX_W-1:0] IDX_CURR_COUNT = 6'd57;
  localparam logic [IDX_W-1:0] IDX_DIVIDE     = 6'd62;

  // decoded register selects
  localparam logic [SEL_W-1:0] SEL_NONE = 4'd0;
  localparam logic [SEL_W-1:0] SEL_TPR  = 4'd1;
  localparam logic [SEL_W-1:0] SEL_EOI  = 4'd2;
  localparam logic [SEL_W-1:0] SEL_SVR  = 4'd3;
  localparam logic [SEL_W-1:0] SEL_ICRL = 4'd4;
  localparam logic [SEL_W-1:0] SEL_ICRH = 4'd5;
  localparam logic [SEL_W-1:0] SEL_LVT  = 4'd6;
  localparam logic [SEL_W-1:0] SEL_INIT = 4'd7;
  localparam logic [SEL_W-1:0] SEL_CURR = 4'd8;
  localparam logic [SEL_W-1:0] SEL_DIV  = 4'd9;

  localparam logic [3:0]        DIVIDE_BY_ONE     = 4'b1011;
  localparam logic [3:0]        DIVIDE_MASK       = 4'b1011;
  localparam logic [1:0]        TIMER_MODE_RELOAD = 2'b01;
  localparam logic [8:0]        SVR_RESET         = 9'h0FF;
  localparam logic [DATA_W-1:0] ICR_STATUS_CLR    = 32'hFFFF_EFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SEL_W-1:0]  sel;
    logic [DATA_W-1:0] data;
  } op_t;

endpackage

// File: rtl/lirt_front.sv
module lirt_front
  import lirt_pkg::*;
(
  input  logic [CMD_W-1:0]  cmd,
  input  logic [IDX_W-1:0]  reg_index,
  input  logic [DATA_W-1:0] write_data,
  output op_t               op
);

  logic [SEL_W-1:0] sel;

  always_comb begin
    case (reg_index)
      IDX_TPR:        sel = SEL_TPR;
      IDX_EOI:        sel = SEL_EOI;
      IDX_SVR:        sel = SEL_SVR;
      IDX_ICR_LO:     sel = SEL_ICRL;
      IDX_ICR_HI:     sel = SEL_ICRH;
      IDX_LVT_TIMER:  sel = SEL_LVT;
      IDX_INIT_COUNT: sel = SEL_INIT;
      IDX_CURR_COUNT: sel = SEL_CURR;
      IDX_DIVIDE:     sel = SEL_DIV;
      default:        sel = SEL_NONE;
    endcase
  end

  assign op.cmd  = cmd;
  assign op.sel  = sel;
  assign op.data = write_data;

endmodule

// File: rtl/lirt_queue.sv
module lirt_queue
  import lirt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  op_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_op     = mem_r[rd_ptr_r];

  // pointers wrap at the depth, which need not be a power of two
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: rtl/lirt_back.sv
module lirt_back
  import lirt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [71:0] res_data
);

  logic [COUNT_WIDTH-1:0] cur_cnt_r, cur_cnt_nxt;
  logic [COUNT_WIDTH-1:0] init_cnt_r, init_cnt_nxt;
  logic [7:0]             tvec_r, tvec_nxt;
  logic                   tmask_r, tmask_nxt;
  logic [1:0]             tmode_r, tmode_nxt;
  logic [3:0]             div_r, div_nxt;
  logic [6:0]             pre_r, pre_nxt;
  logic [7:0]             tpr_r, tpr_nxt;
  logic [8:0]             svr_r, svr_nxt;
  logic [DATA_W-1:0]      icrl_r, icrl_nxt;
  logic [DATA_W-1:0]      icrh_r, icrh_nxt;

  logic              res_valid_r;
  logic [71:0]       res_data_r;
  logic              take;
  logic [2:0]        div_sh;
  logic [7:0]        divisor;
  logic              wrap;

  logic [DATA_W-1:0] rd_data;
  logic              fire;
  logic [7:0]        fire_vec;
  logic              ipi;
  logic              eoi;

  assign op_ready  = !res_valid_r || res_ready;
  assign take      = op_valid && op_ready;
  assign res_valid = res_valid_r;
  assign res_data  = res_data_r;

  assign div_sh  = {div_r[3], div_r[1:0]};
  assign divisor = (div_r == DIVIDE_BY_ONE) ? 8'd1 : (8'd2 << div_sh);
  assign wrap    = ({1'b0, pre_r} + 8'd1) >= divisor;

  always_comb begin
    case (op.sel)
      SEL_TPR:  rd_data = {24'd0, tpr_r};
      SEL_SVR:  rd_data = {23'd0, svr_r};
      SEL_ICRL: rd_data = icrl_r & ICR_STATUS_CLR;
      SEL_ICRH: rd_data = icrh_r;
      SEL_LVT:  rd_data = {13'd0, tmode_r, tmask_r, 8'd0, tvec_r};
      SEL_INIT: rd_data = DATA_W'(init_cnt_r);
      SEL_CURR: rd_data = DATA_W'(cur_cnt_r);
      SEL_DIV:  rd_data = {28'd0, div_r};
      default:  rd_data = '0;
    endcase
  end

  always_comb begin
    cur_cnt_nxt  = cur_cnt_r;
    init_cnt_nxt = init_cnt_r;
    tvec_nxt     = tvec_r;
    tmask_nxt    = tmask_r;
    tmode_nxt    = tmode_r;
    div_nxt      = div_r;
    pre_nxt      = pre_r;
    tpr_nxt      = tpr_r;
    svr_nxt      = svr_r;
    icrl_nxt     = icrl_r;
    icrh_nxt     = icrh_r;
    fire         = 1'b0;
    fire_vec     = '0;
    ipi          = 1'b0;
    eoi          = 1'b0;
    case (op.cmd)
      CMD_TICK: begin
        if (wrap) begin
          pre_nxt = '0;
          if (cur_cnt_r != '0) begin
            cur_cnt_nxt = cur_cnt_r - 1'b1;
            // count hits zero on this step
            if (cur_cnt_r == COUNT_WIDTH'(1)) begin
              if (!tmask_r) begin
                fire     = 1'b1;
                fire_vec = tvec_r;
              end
              if (tmode_r == TIMER_MODE_RELOAD) begin
                cur_cnt_nxt = init_cnt_r;
              end
            end
          end
        end else begin
          pre_nxt = pre_r + 1'b1;
        end
      end
      CMD_WRITE: begin
        case (op.sel)
          SEL_TPR:  tpr_nxt = op.data[7:0];
          SEL_EOI:  eoi = 1'b1;
          SEL_SVR:  svr_nxt = op.data[8:0];
          SEL_ICRL: begin
            icrl_nxt = op.data & ICR_STATUS_CLR;
            ipi      = 1'b1;
          end
          SEL_ICRH: icrh_nxt = op.data;
          SEL_LVT: begin
            tvec_nxt  = op.data[7:0];
            tmask_nxt = op.data[16];
            tmode_nxt = op.data[18:17];
          end
          SEL_INIT: begin
            init_cnt_nxt = op.data[COUNT_WIDTH-1:0];
            cur_cnt_nxt  = op.data[COUNT_WIDTH-1:0];
          end
          SEL_DIV:  div_nxt = op.data[3:0] & DIVIDE_MASK;
          default:  ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r   <= '0;
      init_cnt_r  <= '0;
      tvec_r      <= '0;
      tmask_r     <= 1'b1;
      tmode_r     <= '0;
      div_r       <= '0;
      pre_r       <= '0;
      tpr_r       <= '0;
      svr_r       <= SVR_RESET;
      icrl_r      <= '0;
      icrh_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (take) begin
        cur_cnt_r  <= cur_cnt_nxt;
        init_cnt_r <= init_cnt_nxt;
        tvec_r     <= tvec_nxt;
        tmask_r    <= tmask_nxt;
        tmode_r    <= tmode_nxt;
        div_r      <= div_nxt;
        pre_r      <= pre_nxt;
        tpr_r      <= tpr_nxt;
        svr_r      <= svr_nxt;
        icrl_r     <= icrl_nxt;
        icrh_r     <= icrh_nxt;
      end
      if (op_ready) begin
        res_valid_r <= op_valid;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      res_data_r[31:0]  <= (op.cmd == CMD_READ) ? rd_data : '0;
      res_data_r[32]    <= fire;
      res_data_r[40:33] <= fire_vec;
      res_data_r[41]    <= ipi;
      res_data_r[49:42] <= ipi ? op.data[7:0]   : 8'd0;
      res_data_r[52:50] <= ipi ? op.data[10:8]  : 3'd0;
      res_data_r[53]    <= ipi ? op.data[14]    : 1'b0;
      res_data_r[55:54] <= ipi ? op.data[19:18] : 2'd0;
      res_data_r[63:56] <= ipi ? icrh_r[31:24]  : 8'd0;
      res_data_r[64]    <= eoi;
      res_data_r[71:65] <= '0;
    end
  end

endmodule

// File: rtl/local_interrupt_timer_regs.sv
// channel  | direction | signals                           | request
// ---------+-----------+-----------------------------------+----------------------------------
// in       | slave     | in_tvalid in_tready in_tdata/tuser | one tick, register write or read
// out      | master    | out_tvalid out_tready out_tdata   | one result per accepted request
//
// one request per clock sustained while the output is not stalled; an accepted request is
// written into the queue, then the back end takes it and loads the result register
// the execute stage's combinational update (prescale compare, count decrement) sets the rate
// rst_n is synchronous, active low: timer masked, spurious vector 0xff, all else zero
// a stalled output holds the result; the queue keeps accepting until both entries fill
module local_interrupt_timer_regs
  import lirt_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // reg_index [5:0], write_data [37:6], zero pad [39:38]
  input  logic [39:0] in_tdata,
  // command [1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data [31:0], timer_fire [32], timer_vector_out [40:33], ipi_send [41],
  // ipi_vector [49:42], ipi_delivery [52:50], ipi_level [53], ipi_shorthand [55:54],
  // ipi_dest [63:56], eoi_seen [64], zero pad [71:65]
  output logic [71:0] out_tdata
);

  op_t  front_op;
  op_t  back_op;
  logic back_valid;
  logic back_ready;

  // front end: classify the register index
  lirt_front u_front (
    .cmd        (in_tuser),
    .reg_index  (in_tdata[5:0]),
    .write_data (in_tdata[37:6]),
    .op         (front_op)
  );

  // short queue decouples request intake from execution
  lirt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_op     (back_op)
  );

  // back end: register file, prescaler, counter and result register
  lirt_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (back_valid),
    .op_ready  (back_ready),
    .op        (back_op),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (out_tdata)
  );

endmodule

// File: tb/local_interrupt_timer_regs_test.sv
`timescale 1ns / 1ps

module local_interrupt_timer_regs_test;
  import lirt_pkg::*;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [IDX_W-1:0] IDX_SPARE  = 6'd63;

  localparam int RANDOM_REQUESTS = 1000;
  localparam int QUIET_TAIL      = 150;    // last requests run with no idling
  localparam int WATCHDOG_LIMIT  = 1000;   // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 8;      // queue and result register plus margin
  localparam int PRINT_LIMIT     = 50;

  // one result, laid out exactly as out_tdata[64:0] (msb first)
  typedef struct packed {
    logic        eoi_seen;
    logic [7:0]  ipi_dest;
    logic [1:0]  ipi_shorthand;
    logic        ipi_level;
    logic [2:0]  ipi_delivery;
    logic [7:0]  ipi_vector;
    logic        ipi_send;
    logic [7:0]  timer_vector_out;
    logic        timer_fire;
    logic [31:0] read_data;
  } timer_result_t;

  // one request plus an optional typed-in result
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    bit                typed;
    timer_result_t     golden;
  } request_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [71:0] out_tdata;

  // typed-in result travelling beside the request being driven
  bit            drv_typed = 1'b0;
  timer_result_t drv_golden = '0;

  int idle_pct = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  timer_result_t awaited_results[$];
  request_row_t  directed_rows[$];

  logic [IDX_W-1:0] mapped_idx [9] = '{IDX_TPR, IDX_EOI, IDX_SVR, IDX_ICR_LO, IDX_ICR_HI,
                                       IDX_LVT_TIMER, IDX_INIT_COUNT, IDX_CURR_COUNT,
                                       IDX_DIVIDE};

  // predictor copy of the register file and timer
  logic [31:0] cnt_current = '0;
  logic [31:0] cnt_initial = '0;
  logic [7:0]  lvt_vector = '0;
  logic        lvt_masked = 1'b1;
  logic [1:0]  lvt_mode = '0;
  logic [3:0]  div_code = '0;
  logic [6:0]  prescale = '0;
  logic [7:0]  tpr_value = '0;
  logic [8:0]  svr_value = 9'h0FF;
  logic [31:0] icr_low = '0;
  logic [31:0] icr_high = '0;

  local_interrupt_timer_regs u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // advance the timer model by one request and return the result it yields
  task automatic step_timer_regs(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] data, output timer_result_t res);
    int divisor;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        divisor = (div_code == DIVIDE_BY_ONE) ? 1 : (2 << {div_code[3], div_code[1:0]});
        if (int'(prescale) + 1 >= divisor) begin
          // prescaler wraps, also when a new divide code left it past the divisor
          prescale = '0;
          if (cnt_current != 0) begin
            cnt_current = cnt_current - 1;
            if (cnt_current == 0) begin
              if (!lvt_masked) begin
                res.timer_fire = 1'b1;
                res.timer_vector_out = lvt_vector;
              end
              // modes other than periodic behave as one shot
              if (lvt_mode == TIMER_MODE_RELOAD) cnt_current = cnt_initial;
            end
          end
        end else begin
          prescale = prescale + 1;
        end
      end
      CMD_WRITE: begin
        case (idx)
          IDX_TPR:        tpr_value = data[7:0];
          IDX_EOI:        res.eoi_seen = 1'b1;
          IDX_SVR:        svr_value = data[8:0];
          IDX_ICR_LO: begin
            icr_low = data;
            icr_low[12] = 1'b0;   // delivery status never stored
            res.ipi_send = 1'b1;
            res.ipi_vector = data[7:0];
            res.ipi_delivery = data[10:8];
            res.ipi_level = data[14];
            res.ipi_shorthand = data[19:18];
            res.ipi_dest = icr_high[31:24];
          end
          IDX_ICR_HI:     icr_high = data;
          IDX_LVT_TIMER: begin
            lvt_vector = data[7:0];
            lvt_masked = data[16];
            lvt_mode = data[18:17];
          end
          IDX_INIT_COUNT: begin
            cnt_initial = data;
            cnt_current = data;
          end
          IDX_DIVIDE:     div_code = data[3:0] & DIVIDE_MASK;
          default: ;      // current count and unmapped words store nothing
        endcase
      end
      CMD_READ: begin
        case (idx)
          IDX_TPR:        res.read_data = {24'h0, tpr_value};
          IDX_SVR:        res.read_data = {23'h0, svr_value};
          IDX_ICR_LO:     res.read_data = icr_low;
          IDX_ICR_HI:     res.read_data = icr_high;
          IDX_LVT_TIMER:  res.read_data = {13'h0, lvt_mode, lvt_masked, 8'h0, lvt_vector};
          IDX_INIT_COUNT: res.read_data = cnt_initial;
          IDX_CURR_COUNT: res.read_data = cnt_current;
          IDX_DIVIDE:     res.read_data = {28'h0, div_code};
          default:        res.read_data = '0;
        endcase
      end
      default: ;          // unused command leaves everything at zero
    endcase
  endtask

  function automatic request_row_t req_row(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] data, input bit typed,
                                           input timer_result_t golden);
    request_row_t row;
    row.cmd = cmd;
    row.idx = idx;
    row.data = data;
    row.typed = typed;
    row.golden = golden;
    return row;
  endfunction

  function automatic timer_result_t read_back(input logic [31:0] value);
    timer_result_t res;
    res = '0;
    res.read_data = value;
    return res;
  endfunction

  // mostly ticks and register writes that keep the timer firing:
  // small counts, fast divide codes, mask clear most of the time
  function automatic request_row_t random_request();
    int pick;
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    pick = $urandom_range(0, 99);
    if (pick < 45) cmd = CMD_TICK;
    else if (pick < 78) cmd = CMD_WRITE;
    else if (pick < 97) cmd = CMD_READ;
    else cmd = CMD_UNUSED;
    if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, 63));
    else idx = mapped_idx[$urandom_range(0, 8)];
    data = $urandom;
    if (cmd == CMD_WRITE) begin
      case (idx)
        IDX_INIT_COUNT: if ($urandom_range(0, 7) != 0) data = $urandom_range(0, 24);
        IDX_DIVIDE: begin
          case ($urandom_range(0, 3))
            0: data[3:0] = DIVIDE_BY_ONE;
            1: data[3:0] = 4'b0000;
            2: data[3:0] = 4'b0001;
            default: ;
          endcase
        end
        IDX_LVT_TIMER: data[16] = ($urandom_range(0, 3) == 0);
        default: ;
      endcase
    end
    return req_row(cmd, idx, data, 1'b0, '0);
  endfunction

  // hold the request until the handshake, with an optional gap first
  task automatic send_request(input request_row_t row);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= row.cmd;
    in_tdata <= {2'b00, row.data, row.idx};
    drv_typed <= row.typed;
    drv_golden <= row.golden;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // result side stalls in bursts of random length
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // predict on each accepted request, check each accepted result, watch for a hang
  always @(posedge clk) begin
    timer_result_t predicted;
    timer_result_t got;
    timer_result_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (in_tvalid && in_tready) begin
        step_timer_regs(in_tuser, in_tdata[5:0], in_tdata[37:6], predicted);
        awaited_results.push_back(drv_typed ? drv_golden : predicted);
        quiet_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[64:0];
        quiet_cycles = 0;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, read_data", got.read_data, '0);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.timer_fire !== want.timer_fire)
            report_mismatch("timer_fire", got.timer_fire, want.timer_fire);
          if (got.timer_vector_out !== want.timer_vector_out)
            report_mismatch("timer_vector_out", got.timer_vector_out, want.timer_vector_out);
          if (got.ipi_send !== want.ipi_send)
            report_mismatch("ipi_send", got.ipi_send, want.ipi_send);
          if (got.ipi_vector !== want.ipi_vector)
            report_mismatch("ipi_vector", got.ipi_vector, want.ipi_vector);
          if (got.ipi_delivery !== want.ipi_delivery)
            report_mismatch("ipi_delivery", got.ipi_delivery, want.ipi_delivery);
          if (got.ipi_level !== want.ipi_level)
            report_mismatch("ipi_level", got.ipi_level, want.ipi_level);
          if (got.ipi_shorthand !== want.ipi_shorthand)
            report_mismatch("ipi_shorthand", got.ipi_shorthand, want.ipi_shorthand);
          if (got.ipi_dest !== want.ipi_dest)
            report_mismatch("ipi_dest", got.ipi_dest, want.ipi_dest);
          if (got.eoi_seen !== want.eoi_seen)
            report_mismatch("eoi_seen", got.eoi_seen, want.eoi_seen);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    directed_rows = '{
      // reset values
      req_row(CMD_READ,   IDX_SVR,        32'h0, 1'b1, read_back(32'h0000_00FF)),
      req_row(CMD_READ,   IDX_LVT_TIMER,  32'h0, 1'b1, read_back(32'h0001_0000)),
      req_row(CMD_READ,   IDX_DIVIDE,     32'h0, 1'b1, read_back(32'h0)),
      // idle counter neither steps nor fires
      req_row(CMD_TICK,   IDX_SPARE,      32'hFFFF_FFFF, 1'b1, '0),
      // unused command, unmapped word, read-only current count
      req_row(CMD_UNUSED, IDX_INIT_COUNT, 32'hFFFF_FFFF, 1'b1, '0),
      req_row(CMD_WRITE,  IDX_SPARE,      32'hFFFF_FFFF, 1'b1, '0),
      req_row(CMD_READ,   IDX_SPARE,      32'h0, 1'b1, read_back(32'h0)),
      req_row(CMD_WRITE,  IDX_CURR_COUNT, 32'hFFFF_FFFF, 1'b1, '0),
      req_row(CMD_READ,   IDX_CURR_COUNT, 32'h0, 1'b1, read_back(32'h0)),
      // all-ones writes keep only the implemented bits
      req_row(CMD_WRITE,  IDX_TPR,        32'hFFFF_FFFF, 1'b1, '0),
      req_row(CMD_READ,   IDX_TPR,        32'h0, 1'b1, read_back(32'h0000_00FF)),
      req_row(CMD_WRITE,  IDX_SVR,        32'hFFFF_FFFF, 1'b1, '0),
      req_row(CMD_READ,   IDX_SVR,        32'h0, 1'b1, read_back(32'h0000_01FF)),
      req_row(CMD_WRITE,  IDX_ICR_HI,     32'hFFFF_FFFF, 1'b1, '0),
      req_row(CMD_WRITE,  IDX_ICR_LO,     32'hFFFF_FFFF, 1'b1,
              timer_result_t'({1'b0, 8'hFF, 2'd3, 1'b1, 3'd7, 8'hFF, 1'b1, 8'h00, 1'b0,
                               32'h0})),
      req_row(CMD_READ,   IDX_ICR_LO,     32'h0, 1'b1, read_back(32'hFFFF_EFFF)),
      // end of interrupt pulses its flag and nothing else
      req_row(CMD_WRITE,  IDX_EOI,        32'hFFFF_FFFF, 1'b1,
              timer_result_t'({1'b1, 64'h0})),
      req_row(CMD_READ,   IDX_EOI,        32'h0, 1'b1, read_back(32'h0)),
      // periodic timer at divide by one: fires every second tick
      req_row(CMD_WRITE,  IDX_DIVIDE,     32'hFFFF_FFFF, 1'b0, '0),
      req_row(CMD_WRITE,  IDX_LVT_TIMER,  32'h0002_00A5, 1'b0, '0),
      req_row(CMD_WRITE,  IDX_INIT_COUNT, 32'h0000_0002, 1'b0, '0),
      req_row(CMD_TICK,   IDX_TPR,        32'h0, 1'b0, '0),
      req_row(CMD_TICK,   IDX_TPR,        32'h0, 1'b0, '0),
      req_row(CMD_TICK,   IDX_TPR,        32'h0, 1'b0, '0),
      // zero initial count stops the timer, then full-scale count
      req_row(CMD_WRITE,  IDX_INIT_COUNT, 32'h0, 1'b0, '0),
      req_row(CMD_WRITE,  IDX_INIT_COUNT, 32'hFFFF_FFFF, 1'b0, '0),
      req_row(CMD_READ,   IDX_CURR_COUNT, 32'h0, 1'b0, '0)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 25;
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // stretches of differing idle rates, none at all near the end
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      if (n >= RANDOM_REQUESTS - QUIET_TAIL) idle_pct = 0;
      send_request(random_request());
    end
    in_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: local_interrupt_timer_regs.f
rtl/lirt_pkg.sv
rtl/lirt_front.sv
rtl/lirt_queue.sv
rtl/lirt_back.sv
rtl/local_interrupt_timer_regs.sv
tb/local_interrupt_timer_regs_test.sv
